@@ rtl/ppsc_pkg.sv @@
package ppsc_pkg;

  localparam int unsigned TaskSlots    = 8;
  localparam int unsigned SlotBits     = $clog2(TaskSlots);
  localparam int unsigned TimeBits     = 16;
  localparam int unsigned PriorityBits = 8;

  localparam logic OpArrive = 1'b0;
  localparam logic OpTick   = 1'b1;

  // Candidate travelling down the cell chain during a scan.
  typedef struct packed {
    logic                    go;
    logic                    valid;
    logic [PriorityBits-1:0] prio;
    logic [TimeBits-1:0]     age;
    logic [SlotBits-1:0]     slot;
  } cand_t;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic                    alloc;
    logic                    run;
    logic [SlotBits-1:0]     slot;
    logic [PriorityBits-1:0] prio;
    logic [TimeBits-1:0]     service;
    logic [TimeBits-1:0]     now;
  } cmd_t;

  // Status reported by each cell.
  typedef struct packed {
    logic                busy;
    logic                fin;
    logic [TimeBits-1:0] wait_time;
    logic [TimeBits-1:0] turnaround;
  } info_t;

endpackage

@@ rtl/ppsc_cell.sv @@
module ppsc_cell import ppsc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [SlotBits-1:0] idx_i,
  input  cmd_t                cmd_i,
  input  cand_t               cand_i,
  output cand_t               cand_o,
  output info_t               info_o
);

  logic                    busy_q, busy_d;
  logic                    started_q, started_d;
  logic                    go_q;
  logic [TimeBits-1:0]     arrival_q, arrival_d;
  logic [TimeBits-1:0]     remain_q, remain_d;
  logic [PriorityBits-1:0] prio_q, prio_d;
  logic [TimeBits-1:0]     wait_q, wait_d;
  cand_t                   cand_q, cand_d;
  logic [TimeBits-1:0]     age;
  logic                    hit;
  logic                    own_wins;

  assign age = cmd_i.now - arrival_q;
  assign hit = (cmd_i.slot == idx_i);

  always_comb begin
    own_wins = 1'b0;
    if (busy_q) begin
      if (!cand_i.valid) begin
        own_wins = 1'b1;
      end else if (prio_q < cand_i.prio) begin
        own_wins = 1'b1;
      end else if ((prio_q == cand_i.prio) && (age > cand_i.age)) begin
        own_wins = 1'b1;
      end
    end
    cand_d = cand_i;
    if (own_wins) begin
      cand_d.valid = 1'b1;
      cand_d.prio  = prio_q;
      cand_d.age   = age;
      cand_d.slot  = idx_i;
    end
  end

  always_comb begin
    info_o.busy       = busy_q;
    info_o.fin        = (remain_q <= TimeBits'(1));
    info_o.wait_time  = started_q ? wait_q : age;
    info_o.turnaround = age + TimeBits'(1);
  end

  always_comb begin
    busy_d    = busy_q;
    started_d = started_q;
    arrival_d = arrival_q;
    remain_d  = remain_q;
    prio_d    = prio_q;
    wait_d    = wait_q;
    if (cmd_i.alloc && hit) begin
      busy_d    = 1'b1;
      started_d = 1'b0;
      arrival_d = cmd_i.now;
      remain_d  = cmd_i.service;
      prio_d    = cmd_i.prio;
    end else if (cmd_i.run && hit) begin
      if (!started_q) begin
        started_d = 1'b1;
        wait_d    = age;
      end
      if (remain_q <= TimeBits'(1)) begin
        busy_d    = 1'b0;
        started_d = 1'b0;
        remain_d  = '0;
      end else begin
        remain_d = remain_q - TimeBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      started_q <= 1'b0;
      go_q      <= 1'b0;
    end else begin
      busy_q    <= busy_d;
      started_q <= started_d;
      go_q      <= cand_i.go;
    end
  end

  always_ff @(posedge clk_i) begin
    arrival_q <= arrival_d;
    remain_q  <= remain_d;
    prio_q    <= prio_d;
    wait_q    <= wait_d;
    cand_q    <= cand_d;
  end

  always_comb begin
    cand_o    = cand_q;
    cand_o.go = go_q;
  end

endmodule

@@ rtl/preemptive_priority_scheduler_core.sv @@
// Arrive word: once accepted it goes to the done state, which registers the result
// when the output is free. Tick word: the candidate passes through the slot chain, one
// cell per cycle, then the winner is registered and the done state registers the result.
// One word is in work at a time; the next is taken once the result is registered.
// Reset is asynchronous and active low; it clears the time, the busy and started
// flags of every slot and the handshake state. Slot contents are written on arrival.
module preemptive_priority_scheduler_core import ppsc_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    operation_i,
  input  logic [PriorityBits-1:0] task_priority_i,
  input  logic [TimeBits-1:0]     service_time_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [SlotBits-1:0]     slot_o,
  output logic                    accepted_o,
  output logic                    ran_o,
  output logic                    finished_o,
  output logic [TimeBits-1:0]     wait_time_o,
  output logic [TimeBits-1:0]     turnaround_o,
  output logic [TimeBits-1:0]     time_now_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e                  state_q, state_d;
  logic                    launch_q, launch_d;
  logic                    op_q;
  logic [PriorityBits-1:0] prio_q;
  logic [TimeBits-1:0]     service_q;
  logic [TimeBits-1:0]     time_q, time_d;
  cand_t                   best_q;
  logic                    out_valid_q, out_valid_d;
  logic [SlotBits-1:0]     slot_q, slot_d;
  logic                    accepted_q, accepted_d;
  logic                    ran_q, ran_d;
  logic                    finished_q, finished_d;
  logic [TimeBits-1:0]     wait_q, wait_d;
  logic [TimeBits-1:0]     tat_q, tat_d;
  logic                    in_accept;
  logic                    load;
  logic                    free_found;
  logic [SlotBits-1:0]     free_slot;
  logic [TaskSlots-1:0]    busy;
  cmd_t                    cmd;
  cand_t                   chain [TaskSlots+1];
  info_t                   info  [TaskSlots];
  info_t                   sel;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign load       = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    chain[0]       = '0;
    chain[0].go    = launch_q;
    chain[0].valid = 1'b0;
  end

  for (genvar g = 0; g < TaskSlots; g++) begin : g_cell
    ppsc_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (SlotBits'(g)),
      .cmd_i  (cmd),
      .cand_i (chain[g]),
      .cand_o (chain[g+1]),
      .info_o (info[g])
    );
    assign busy[g] = info[g].busy;
  end

  always_comb begin
    free_found = 1'b0;
    free_slot  = '0;
    for (int k = TaskSlots - 1; k >= 0; k--) begin
      if (!busy[k]) begin
        free_found = 1'b1;
        free_slot  = SlotBits'(k);
      end
    end
  end

  assign sel = info[best_q.slot];

  always_comb begin
    cmd         = '0;
    cmd.now     = time_q;
    cmd.prio    = prio_q;
    cmd.service = service_q;
    cmd.slot    = (op_q == OpArrive) ? free_slot : best_q.slot;
    if (load) begin
      cmd.alloc = (op_q == OpArrive) && free_found;
      cmd.run   = (op_q == OpTick) && best_q.valid;
    end
  end

  always_comb begin
    state_d     = state_q;
    launch_d    = 1'b0;
    time_d      = time_q;
    out_valid_d = out_valid_q && out_stall_i;
    slot_d      = slot_q;
    accepted_d  = accepted_q;
    ran_d       = ran_q;
    finished_d  = finished_q;
    wait_d      = wait_q;
    tat_d       = tat_q;
    case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          launch_d = (operation_i == OpTick);
          state_d  = (operation_i == OpTick) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (chain[TaskSlots].go) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
          slot_d      = '0;
          accepted_d  = 1'b0;
          ran_d       = 1'b0;
          finished_d  = 1'b0;
          wait_d      = '0;
          tat_d       = '0;
          if (op_q == OpArrive) begin
            if (free_found) begin
              slot_d     = free_slot;
              accepted_d = 1'b1;
            end
          end else begin
            time_d = time_q + TimeBits'(1);
            if (best_q.valid) begin
              slot_d = best_q.slot;
              ran_d  = 1'b1;
              if (sel.fin) begin
                finished_d = 1'b1;
                wait_d     = sel.wait_time;
                tat_d      = sel.turnaround;
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      launch_q    <= 1'b0;
      time_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      launch_q    <= launch_d;
      time_q      <= time_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= operation_i;
      prio_q    <= task_priority_i;
      service_q <= service_time_i;
    end
    if ((state_q == ST_SCAN) && chain[TaskSlots].go) begin
      best_q <= chain[TaskSlots];
    end
    slot_q     <= slot_d;
    accepted_q <= accepted_d;
    ran_q      <= ran_d;
    finished_q <= finished_d;
    wait_q     <= wait_d;
    tat_q      <= tat_d;
  end

  assign out_valid_o  = out_valid_q;
  assign slot_o       = slot_q;
  assign accepted_o   = accepted_q;
  assign ran_o        = ran_q;
  assign finished_o   = finished_q;
  assign wait_time_o  = wait_q;
  assign turnaround_o = tat_q;
  assign time_now_o   = time_q;

  a_scan_end_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chain[TaskSlots].go |-> (state_q == ST_SCAN))
    else $error("scan wave left the chain outside of a scan");

  a_run_busy_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.run |-> busy[cmd.slot])
    else $error("run command targets a free slot");

  a_alloc_free_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.alloc |-> !busy[cmd.slot])
    else $error("allocation targets a busy slot");

  a_finish_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.run && sel.fin) |=> !busy[$past(cmd.slot)])
    else $error("finished task still holds its slot");

  a_time_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (time_q != $past(time_q)) |-> (time_q == $past(time_q) + TimeBits'(1)))
    else $error("time moved by more than one unit");

endmodule
